[rtl/sxt_pkg.sv]
// Shared types, character constants and helper functions of the s-expression tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sxt_pkg;

   // Kinds of token that a result beat carries.
   typedef enum logic [3:0] {
      KIND_LPAREN = 4'd0,
      KIND_RPAREN = 4'd1,
      KIND_NUMBER = 4'd2,
      KIND_TICK   = 4'd3,
      KIND_STRING = 4'd4,
      KIND_SYMBOL = 4'd5,
      KIND_NIL    = 4'd6,
      KIND_END    = 4'd7,
      KIND_ERROR  = 4'd8
   } token_kind_type;

   // Error codes reported with an error beat.
   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_UNTERM_STRING = 3'd1,
      ERR_EOF_STR_ESC   = 3'd2,
      ERR_EOF_TICK      = 3'd3,
      ERR_BAD_CHAR_ESC  = 3'd4,
      ERR_OVERFLOW      = 3'd5
   } error_code_type;

   // Lexer modes between bytes.
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_NUM   = 4'd1,
      MODE_MINUS = 4'd2,
      MODE_TICK  = 4'd3,
      MODE_CESC  = 4'd4,
      MODE_CSWAL = 4'd5,
      MODE_STR   = 4'd6,
      MODE_SESC  = 4'd7,
      MODE_SYM   = 4'd8,
      MODE_HALT  = 4'd9
   } lex_mode_type;

   // One result beat.
   typedef struct packed {
      token_kind_type      kind;
      logic signed [31:0]  number_value;
      logic [7:0]          text_byte;
      logic                has_byte;
      logic                token_end;
      error_code_type      error_code;
      logic                last_result;
   } result_type;

   // Results produced by one source beat: up to two, in order.
   typedef struct packed {
      result_type  res0;
      result_type  res1;
      logic [1:0]  count;
   } lex_out_type;

   // Status of the result queue.
   typedef struct packed {
      logic        valid;
      logic        room_two;
      logic [2:0]  level;
   } queue_stat_type;

   localparam int QUEUE_DEPTH = 4;

   // Character constants.
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_TICK   = 8'h27;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HT     = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CODE_LF   = 8'd10;
   localparam logic [7:0] CODE_TAB  = 8'd9;

   // Spelling of the nil symbol.
   localparam logic [7:0] NIL_TEXT [3] = '{8'h6e, 8'h69, 8'h6c};

   // Largest magnitude a number may have.
   localparam logic [30:0] MAG_MAX = '1;

   // Advance the nil match count by one symbol byte; four means no match.
   function automatic logic [2:0] nil_track(input logic [2:0] cnt, input logic [7:0] b);
      logic [2:0] res;
      res = 3'd4;
      if (cnt < 3'd3) begin
         if (b == NIL_TEXT[cnt[1:0]]) begin
            res = cnt + 3'd1;
         end
      end
      return res;
   endfunction

   // Build a result beat; the last flag is set later.
   function automatic result_type mk_res(input token_kind_type kind,
                                         input logic [31:0] value,
                                         input logic [7:0] b,
                                         input logic hasb,
                                         input logic tend,
                                         input error_code_type err);
      result_type r;
      r.kind         = kind;
      r.number_value = value;
      r.text_byte    = b;
      r.has_byte     = hasb;
      r.token_end    = tend;
      r.error_code   = err;
      r.last_result  = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/sxt_lexer.sv]
// Lexer state registers and the single-pass logic that turns one source beat into results.
`timescale 1ns / 1ps
`default_nettype none

module sxt_lexer
   import sxt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire logic [7:0]  src_byte,
   input  wire logic        end_of_source,
   output lex_out_type      lex_out
);

   lex_mode_type  mode_ff, mode_in;
   logic [30:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic          big_ff, big_in;
   logic [2:0]    nil_ff, nil_in;
   logic [7:0]    code_ff, code_in;

   // Byte classes.
   logic        is_space, is_digit, is_delim;
   logic [3:0]  digit;
   assign is_space = (src_byte == CH_SPACE) || ((src_byte >= CH_HT) && (src_byte <= CH_CR));
   assign is_digit = (src_byte >= CH_ZERO) && (src_byte <= CH_NINE);
   assign is_delim = is_space || (src_byte == CH_LPAREN) || (src_byte == CH_RPAREN);
   assign digit    = src_byte[3:0];

   // Decimal accumulate: magnitude times ten plus the new digit.
   logic [34:0] mac;
   logic        mac_over;
   assign mac      = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {31'b0, digit};
   assign mac_over = mac > {4'b0, MAG_MAX};

   // Signed value of the pending number.
   logic [31:0] num_value;
   assign num_value = neg_ff ? (32'd0 - {1'b0, mag_ff}) : {1'b0, mag_ff};

   // Results that close the pending number, symbol or character literal.
   result_type fin_res, close_res, code_res;
   assign fin_res   = big_ff ? mk_res(KIND_ERROR, 32'd0, 8'd0, 1'b0, 1'b1, ERR_OVERFLOW)
                             : mk_res(KIND_NUMBER, num_value, 8'd0, 1'b0, 1'b1, ERR_NONE);
   assign close_res = mk_res((nil_ff == 3'd3) ? KIND_NIL : KIND_SYMBOL,
                             32'd0, 8'd0, 1'b0, 1'b1, ERR_NONE);
   assign code_res  = mk_res(KIND_NUMBER, {24'b0, code_ff}, 8'd0, 1'b0, 1'b1, ERR_NONE);

   // What a byte does when it opens a new token.
   lex_mode_type st_mode;
   logic         st_vld;
   result_type   st_res;
   always_comb begin
      st_mode = MODE_IDLE;
      st_vld  = 1'b0;
      st_res  = mk_res(KIND_SYMBOL, 32'd0, src_byte, 1'b1, 1'b0, ERR_NONE);
      if (is_space) begin
         st_mode = MODE_IDLE;
      end else if (src_byte == CH_LPAREN) begin
         st_vld = 1'b1;
         st_res = mk_res(KIND_LPAREN, 32'd0, 8'd0, 1'b0, 1'b1, ERR_NONE);
      end else if (src_byte == CH_RPAREN) begin
         st_vld = 1'b1;
         st_res = mk_res(KIND_RPAREN, 32'd0, 8'd0, 1'b0, 1'b1, ERR_NONE);
      end else if (is_digit) begin
         st_mode = MODE_NUM;
      end else if (src_byte == CH_MINUS) begin
         st_mode = MODE_MINUS;
      end else if (src_byte == CH_TICK) begin
         st_mode = MODE_TICK;
      end else if (src_byte == CH_QUOTE) begin
         st_mode = MODE_STR;
      end else begin
         st_mode = MODE_SYM;
         st_vld  = 1'b1;
      end
   end

   // Next state of the lexer.
   always_comb begin
      logic do_start;
      do_start = 1'b0;
      mode_in  = mode_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      big_in   = big_ff;
      nil_in   = nil_ff;
      code_in  = code_ff;
      if (fire) begin
         if (end_of_source) begin
            mode_in = MODE_IDLE;
            mag_in  = '0;
            neg_in  = 1'b0;
            big_in  = 1'b0;
            nil_in  = '0;
            code_in = '0;
         end else begin
            case (mode_ff)
               MODE_NUM: begin
                  if (is_digit) begin
                     if (!big_ff) begin
                        if (mac_over) begin
                           big_in = 1'b1;
                        end else begin
                           mag_in = mac[30:0];
                        end
                     end
                  end else if (big_ff) begin
                     mode_in = MODE_HALT;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               MODE_MINUS: begin
                  if (is_digit) begin
                     mag_in  = {27'b0, digit};
                     neg_in  = 1'b1;
                     big_in  = 1'b0;
                     mode_in = MODE_NUM;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               MODE_TICK: begin
                  if (src_byte == CH_LPAREN) begin
                     do_start = 1'b1;
                  end else if (src_byte == CH_BSLASH) begin
                     mode_in = MODE_CESC;
                  end else begin
                     code_in = src_byte;
                     mode_in = MODE_CSWAL;
                  end
               end
               MODE_CESC: begin
                  if (src_byte == CH_LOW_N) begin
                     code_in = CODE_LF;
                     mode_in = MODE_CSWAL;
                  end else if (src_byte == CH_LOW_T) begin
                     code_in = CODE_TAB;
                     mode_in = MODE_CSWAL;
                  end else begin
                     mode_in = MODE_HALT;
                  end
               end
               MODE_CSWAL: begin
                  mode_in = MODE_IDLE;
               end
               MODE_STR: begin
                  if (src_byte == CH_QUOTE) begin
                     mode_in = MODE_IDLE;
                  end else if (src_byte == CH_BSLASH) begin
                     mode_in = MODE_SESC;
                  end
               end
               MODE_SESC: begin
                  mode_in = MODE_STR;
               end
               MODE_SYM: begin
                  if (is_delim) begin
                     do_start = 1'b1;
                  end else begin
                     nil_in = nil_track(nil_ff, src_byte);
                  end
               end
               MODE_HALT: begin
                  mode_in = MODE_HALT;
               end
               default: begin
                  do_start = 1'b1;
               end
            endcase
            // A byte that opens a new token.
            if (do_start) begin
               mode_in = st_mode;
               if (is_digit) begin
                  mag_in = {27'b0, digit};
                  neg_in = 1'b0;
                  big_in = 1'b0;
               end
               if (st_mode == MODE_SYM) begin
                  nil_in = nil_track(3'd0, src_byte);
               end
            end
         end
      end
   end

   // Results of the beat: an optional closing result, then an optional opening one.
   always_comb begin
      logic       a_vld, b_vld;
      result_type a, b;
      a_vld = 1'b0;
      b_vld = 1'b0;
      a     = '0;
      b     = st_res;
      if (fire) begin
         if (end_of_source) begin
            b_vld = 1'b1;
            b     = mk_res(KIND_END, 32'd0, 8'd0, 1'b0, 1'b1, ERR_NONE);
            case (mode_ff)
               MODE_NUM: begin
                  a_vld = 1'b1;
                  a     = fin_res;
               end
               MODE_MINUS: begin
                  a_vld = 1'b1;
                  a     = mk_res(KIND_SYMBOL, 32'd0, CH_MINUS, 1'b1, 1'b1, ERR_NONE);
               end
               MODE_TICK, MODE_CESC: begin
                  a_vld = 1'b1;
                  a     = mk_res(KIND_ERROR, 32'd0, 8'd0, 1'b0, 1'b1, ERR_EOF_TICK);
               end
               MODE_CSWAL: begin
                  a_vld = 1'b1;
                  a     = code_res;
               end
               MODE_STR: begin
                  a_vld = 1'b1;
                  a     = mk_res(KIND_ERROR, 32'd0, 8'd0, 1'b0, 1'b1, ERR_UNTERM_STRING);
               end
               MODE_SESC: begin
                  a_vld = 1'b1;
                  a     = mk_res(KIND_ERROR, 32'd0, 8'd0, 1'b0, 1'b1, ERR_EOF_STR_ESC);
               end
               MODE_SYM: begin
                  a_vld = 1'b1;
                  a     = close_res;
               end
               default: begin
                  a_vld = 1'b0;
               end
            endcase
         end else begin
            case (mode_ff)
               MODE_NUM: begin
                  if (!is_digit) begin
                     a_vld = 1'b1;
                     a     = fin_res;
                     b_vld = !big_ff && st_vld;
                  end
               end
               MODE_MINUS: begin
                  if (!is_digit) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_SYMBOL, 32'd0, CH_MINUS, 1'b1, 1'b1, ERR_NONE);
                     b_vld = st_vld;
                  end
               end
               MODE_TICK: begin
                  if (src_byte == CH_LPAREN) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_TICK, 32'd0, 8'd0, 1'b0, 1'b1, ERR_NONE);
                     b_vld = st_vld;
                  end
               end
               MODE_CESC: begin
                  if ((src_byte != CH_LOW_N) && (src_byte != CH_LOW_T)) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_ERROR, 32'd0, 8'd0, 1'b0, 1'b1, ERR_BAD_CHAR_ESC);
                  end
               end
               MODE_CSWAL: begin
                  a_vld = 1'b1;
                  a     = code_res;
               end
               MODE_STR: begin
                  if (src_byte == CH_QUOTE) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_STRING, 32'd0, 8'd0, 1'b0, 1'b1, ERR_NONE);
                  end else if (src_byte != CH_BSLASH) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_STRING, 32'd0, src_byte, 1'b1, 1'b0, ERR_NONE);
                  end
               end
               MODE_SESC: begin
                  // Unknown escapes are dropped.
                  if (src_byte == CH_LOW_N) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_STRING, 32'd0, CODE_LF, 1'b1, 1'b0, ERR_NONE);
                  end else if (src_byte == CH_LOW_T) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_STRING, 32'd0, CODE_TAB, 1'b1, 1'b0, ERR_NONE);
                  end else if ((src_byte == CH_QUOTE) || (src_byte == CH_BSLASH)) begin
                     a_vld = 1'b1;
                     a     = mk_res(KIND_STRING, 32'd0, src_byte, 1'b1, 1'b0, ERR_NONE);
                  end
               end
               MODE_SYM: begin
                  a_vld = 1'b1;
                  if (is_delim) begin
                     a     = close_res;
                     b_vld = st_vld;
                  end else begin
                     a = mk_res(KIND_SYMBOL, 32'd0, src_byte, 1'b1, 1'b0, ERR_NONE);
                  end
               end
               MODE_HALT: begin
                  a_vld = 1'b0;
               end
               default: begin
                  b_vld = st_vld;
               end
            endcase
         end
      end
      // Pack in order and flag the last result of the beat.
      lex_out.res0  = a_vld ? a : b;
      lex_out.res1  = b;
      lex_out.count = {1'b0, a_vld} + {1'b0, b_vld};
      if (lex_out.count == 2'd2) begin
         lex_out.res1.last_result = 1'b1;
      end else begin
         lex_out.res0.last_result = 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         mag_ff  <= '0;
         neg_ff  <= 1'b0;
         big_ff  <= 1'b0;
         nil_ff  <= '0;
         code_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         big_ff  <= big_in;
         nil_ff  <= nil_in;
         code_ff <= code_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sxt_queue.sv]
// Result queue of four entries that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps
`default_nettype none

module sxt_queue
   import sxt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire lex_out_type lex_out,
   input  wire logic     pop,
   output result_type    head,
   output queue_stat_type stat
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   result_type     mem [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]      level_ff, level_in;

   // Pointer and fill level update.
   always_comb begin
      wr_in    = wr_ff + PtrW'(lex_out.count);
      rd_in    = rd_ff + PtrW'(pop);
      level_in = level_ff + {1'b0, lex_out.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   // Storage writes: the first result of a beat, and the second when there are two.
   always_ff @(posedge clock) begin
      if (lex_out.count != 2'd0) begin
         mem[wr_ff] <= lex_out.res0;
      end
      if (lex_out.count == 2'd2) begin
         mem[wr_ff + PtrW'(1)] <= lex_out.res1;
      end
   end

   assign head          = mem[rd_ff];
   assign stat.valid    = level_ff != 3'd0;
   assign stat.room_two = level_ff <= 3'(QUEUE_DEPTH - 2);
   assign stat.level    = level_ff;

endmodule

`default_nettype wire

[rtl/sexpr_tokenizer.sv]
// Top level of the s-expression tokenizer: source beats in, token result beats out.
//
// The req channel carries one source byte per beat, or an end marker when
// req_end_of_source is high. The rsp channel carries one token result per beat;
// a source beat causes zero, one or two results, and rsp_last_result marks the
// last one of them. Both channels use valid/ready.
// A source beat is lexed in the cycle it is accepted; its results enter a
// four-entry result queue, whose registered head entry drives rsp.
// Throughput is one source beat per cycle while the receiver keeps up; req_ready
// is high whenever the queue has room for two results, so a beat that yields
// two results leaves on rsp as two result beats.
// When the receiver stalls, results wait in the queue and req_ready drops once
// fewer than two entries are free; nothing is lost.
// Reset returns the lexer to idle between tokens and empties the queue.
// After an error the block drops all bytes until the end marker, which gives
// the end result and returns the lexer to its reset state.
`timescale 1ns / 1ps
`default_nettype none

module sexpr_tokenizer
   import sxt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_src_byte,
   input  wire logic               req_end_of_source,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_token_kind,
   output logic signed [31:0]      rsp_number_value,
   output logic [7:0]              rsp_text_byte,
   output logic                    rsp_has_byte,
   output logic                    rsp_token_end,
   output logic [2:0]              rsp_error_code,
   output logic                    rsp_last_result
);

   logic           fire;
   lex_out_type    lex_out;
   result_type     head;
   queue_stat_type stat;

   // Accept a source beat whenever two result slots are free.
   assign req_ready = stat.room_two;
   assign fire      = req_valid && req_ready;

   sxt_lexer u_lexer (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .src_byte      (req_src_byte),
      .end_of_source (req_end_of_source),
      .lex_out       (lex_out)
   );

   sxt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .lex_out (lex_out),
      .pop     (rsp_valid && rsp_ready),
      .head    (head),
      .stat    (stat)
   );

   // Result beat fields.
   assign rsp_valid        = stat.valid;
   assign rsp_token_kind   = head.kind;
   assign rsp_number_value = head.number_value;
   assign rsp_text_byte    = head.text_byte;
   assign rsp_has_byte     = head.has_byte;
   assign rsp_token_end    = head.token_end;
   assign rsp_error_code   = head.error_code;
   assign rsp_last_result  = head.last_result;

   // The queue never holds more than its depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      stat.level <= 3'(QUEUE_DEPTH))
      else $error("result queue level exceeds its depth");

   // Results of an accepted beat always fit in the queue.
   a_room: assert property (@(posedge clock) disable iff (reset)
      fire |-> ({1'b0, stat.level} + {2'b0, lex_out.count}) <= 4'(QUEUE_DEPTH))
      else $error("accepted beat overflows the result queue");

   // An end marker always yields at least the end result next cycle.
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      fire && req_end_of_source |=> rsp_valid)
      else $error("end marker produced no result");

   // Only string and symbol results carry a byte.
   a_byte_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_byte |->
         (rsp_token_kind == KIND_STRING) || (rsp_token_kind == KIND_SYMBOL))
      else $error("payload byte on a result of the wrong kind");

endmodule

`default_nettype wire
